### src/per_object_motion_deadband_filter_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the motion deadband filter
// Shared concurrent assertion forms, reset-qualified on an active-low reset.
// ---------------------------------------------------------------------------
`ifndef PER_OBJECT_MOTION_DEADBAND_FILTER_MACROS_SVH
`define PER_OBJECT_MOTION_DEADBAND_FILTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define POMDF_ASSERT_SAME(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define POMDF_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/pomdf_pkg.sv
// ---------------------------------------------------------------------------
// pomdf_pkg
// Fixed widths, item kind codes and register indexes of the deadband filter.
// ---------------------------------------------------------------------------
`default_nettype none

package pomdf_pkg;

    localparam int HEAD_W      = 17;
    localparam int KIND_W      = 2;
    localparam int SLOT_W      = 8;
    localparam int DIST_THR_W  = 32;
    localparam int ANGLE_THR_W = 17;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 1;

    typedef logic [KIND_W-1:0]    kind_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam kind_t KIND_REPORT = 2'd0;
    localparam kind_t KIND_REMOVE = 2'd1;
    localparam kind_t KIND_CLEAR  = 2'd2;

    localparam cfg_idx_t CFG_DIST_THR  = 1'd0;
    localparam cfg_idx_t CFG_ANGLE_THR = 1'd1;

    localparam logic [DIST_THR_W-1:0]  DIST_THR_RESET  = 32'd100;
    localparam logic [ANGLE_THR_W-1:0] ANGLE_THR_RESET = 17'd100;

endpackage

`default_nettype wire

### src/pomdf_if.sv
// ---------------------------------------------------------------------------
// pomdf channel interfaces
// Valid/ready channels for position reports and for moved results.
// ---------------------------------------------------------------------------
`default_nettype none

interface pomdf_in_if #(
    parameter int POS_W = 24
);
    logic                              valid;
    logic                              ready;
    pomdf_pkg::kind_t                  kind;
    logic [pomdf_pkg::SLOT_W-1:0]      vehicle_slot;
    logic signed [POS_W-1:0]           pos_x;
    logic signed [POS_W-1:0]           pos_y;
    logic signed [pomdf_pkg::HEAD_W-1:0] heading;

    modport source (output valid, kind, vehicle_slot, pos_x, pos_y, heading, input ready);
    modport sink   (input valid, kind, vehicle_slot, pos_x, pos_y, heading, output ready);
endinterface

interface pomdf_out_if;
    logic valid;
    logic ready;
    logic moved;

    modport source (output valid, moved, input ready);
    modport sink   (input valid, moved, output ready);
endinterface

`default_nettype wire

### src/pomdf_ram.sv
// ---------------------------------------------------------------------------
// pomdf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`default_nettype none

module pomdf_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### src/per_object_motion_deadband_filter.sv
// Each word passes the difference, compare and output registers in turn.
// Throughput: one word per cycle while the result channel does not stall; a
// report to the same slot as the report accepted just before it waits for
// that entry's write-back, which the compare stage makes after the table read.
// Reset: thresholds return to their defaults, all slots empty, pipeline flushed;
// slot valid flags live in flip-flops, so no clearing pass follows reset.
// ---------------------------------------------------------------------------
// per_object_motion_deadband_filter
// Report-by-exception filter: passes a position report as moved when it is
// new for its slot, or its squared move or its turn reaches its threshold.
// ---------------------------------------------------------------------------
`default_nettype none
`include "per_object_motion_deadband_filter_macros.svh"

module per_object_motion_deadband_filter #(
    parameter int VEHICLE_SLOTS = 256,
    parameter int POS_WIDTH     = 24
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    pomdf_in_if.sink                              report,
    pomdf_out_if.source                           result,
    input  wire logic                             cfg_we,
    input  wire pomdf_pkg::cfg_idx_t              cfg_index,
    input  wire logic [pomdf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int HW    = pomdf_pkg::HEAD_W;
    localparam int IDX_W = $clog2(VEHICLE_SLOTS);
    localparam int SW    = ((IDX_W > pomdf_pkg::SLOT_W) ? IDX_W : pomdf_pkg::SLOT_W) + 1;
    localparam int DW    = POS_WIDTH + 1;
    localparam int SQ_W  = 2 * DW;
    localparam int CMP_W = (SQ_W + 1 > pomdf_pkg::DIST_THR_W) ? SQ_W + 1
                                                              : pomdf_pkg::DIST_THR_W;
    localparam int DA_W  = HW + 1;
    localparam int ENT_W = 2 * POS_WIDTH + HW;

    // configuration
    logic [pomdf_pkg::DIST_THR_W-1:0]  dist_thr_reg;
    logic [pomdf_pkg::ANGLE_THR_W-1:0] angle_thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_thr_reg  <= pomdf_pkg::DIST_THR_RESET;
            angle_thr_reg <= pomdf_pkg::ANGLE_THR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pomdf_pkg::CFG_DIST_THR:  dist_thr_reg  <= cfg_wdata;
                pomdf_pkg::CFG_ANGLE_THR: angle_thr_reg <= cfg_wdata[pomdf_pkg::ANGLE_THR_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline registers
    logic                 b_valid_reg, b_rep_reg, b_rem_reg, b_clr_reg, b_fwd_reg;
    logic [IDX_W-1:0]     b_idx_reg;
    logic [POS_WIDTH-1:0] b_x_reg, b_y_reg;
    logic [HW-1:0]        b_h_reg;
    logic [ENT_W-1:0]     b_fwd_data_reg;

    logic                 c_valid_reg, c_rep_reg, c_rem_reg, c_clr_reg;
    logic [IDX_W-1:0]     c_idx_reg;
    logic [POS_WIDTH-1:0] c_x_reg, c_y_reg;
    logic [HW-1:0]        c_h_reg;
    logic [SQ_W-1:0]      c_sqx_reg, c_sqy_reg;
    logic [DA_W-1:0]      c_da_reg;

    logic                 o_valid_reg, o_moved_reg;

    logic [VEHICLE_SLOTS-1:0] valid_reg, valid_next;

    // input decode
    logic             advance, accept, hazard;
    logic             in_rep, in_rem, in_clr, in_range;
    logic [SW-1:0]    slot_ext;
    logic [IDX_W-1:0] in_idx;

    assign advance  = !o_valid_reg || result.ready;
    assign slot_ext = SW'(report.vehicle_slot);
    assign in_range = slot_ext < SW'(VEHICLE_SLOTS);
    assign in_idx   = slot_ext[IDX_W-1:0];

    always_comb
    begin
        in_rep = 1'b0;
        in_rem = 1'b0;
        in_clr = 1'b0;
        case (report.kind)
            pomdf_pkg::KIND_REPORT: in_rep = in_range;
            pomdf_pkg::KIND_REMOVE: in_rem = in_range;
            pomdf_pkg::KIND_CLEAR:  in_clr = 1'b1;
            default: ;
        endcase
    end

    // a report right behind a report to the same slot waits for its write-back
    assign hazard       = in_rep && b_valid_reg && b_rep_reg && (b_idx_reg == in_idx);
    assign report.ready = advance && !hazard;
    assign accept       = report.valid && report.ready;

    // compare stage decision and write-back
    logic              c_slot_valid, c_moved, c_wr;
    logic [CMP_W-1:0]  dsq;
    logic [ENT_W-1:0]  c_entry;

    assign c_slot_valid = valid_reg[c_idx_reg];
    assign dsq          = CMP_W'(c_sqx_reg) + CMP_W'(c_sqy_reg);
    assign c_moved      = c_rep_reg && (!c_slot_valid
                                        || (dsq >= CMP_W'(dist_thr_reg))
                                        || (c_da_reg >= DA_W'(angle_thr_reg)));
    assign c_wr         = advance && c_valid_reg && c_moved;
    assign c_entry      = {c_x_reg, c_y_reg, c_h_reg};

    logic [ENT_W-1:0] ram_rdata;

    pomdf_ram #(
        .WIDTH (ENT_W),
        .DEPTH (VEHICLE_SLOTS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (c_wr),
        .waddr (c_idx_reg),
        .wdata (c_entry),
        .re    (accept),
        .raddr (in_idx),
        .rdata (ram_rdata)
    );

    // difference stage: stored entry, or the entry being written as it was read
    logic [ENT_W-1:0]       old_ent;
    logic [POS_WIDTH-1:0]   old_x, old_y;
    logic [HW-1:0]          old_h;
    logic signed [DW-1:0]   dx, dy;
    logic signed [SQ_W-1:0] prod_x, prod_y;
    logic [DA_W-1:0]        dh, da;

    assign old_ent = b_fwd_reg ? b_fwd_data_reg : ram_rdata;
    assign old_x   = old_ent[ENT_W-1 -: POS_WIDTH];
    assign old_y   = old_ent[HW +: POS_WIDTH];
    assign old_h   = old_ent[HW-1:0];

    assign dx     = $signed({b_x_reg[POS_WIDTH-1], b_x_reg}) - $signed({old_x[POS_WIDTH-1], old_x});
    assign dy     = $signed({b_y_reg[POS_WIDTH-1], b_y_reg}) - $signed({old_y[POS_WIDTH-1], old_y});
    assign prod_x = dx * dx;
    assign prod_y = dy * dy;
    assign dh     = {b_h_reg[HW-1], b_h_reg} - {old_h[HW-1], old_h};
    assign da     = dh[DA_W-1] ? (~dh + DA_W'(1)) : dh;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            b_rep_reg   <= 1'b0;
            b_rem_reg   <= 1'b0;
            b_clr_reg   <= 1'b0;
            b_fwd_reg   <= 1'b0;
            c_valid_reg <= 1'b0;
            c_rep_reg   <= 1'b0;
            c_rem_reg   <= 1'b0;
            c_clr_reg   <= 1'b0;
            o_valid_reg <= 1'b0;
            o_moved_reg <= 1'b0;
            valid_reg   <= '0;
        end
        else if (advance)
        begin
            b_valid_reg <= accept;
            b_rep_reg   <= accept && in_rep;
            b_rem_reg   <= accept && in_rem;
            b_clr_reg   <= accept && in_clr;
            b_fwd_reg   <= accept && in_rep && c_wr && (c_idx_reg == in_idx);
            c_valid_reg <= b_valid_reg;
            c_rep_reg   <= b_rep_reg;
            c_rem_reg   <= b_rem_reg;
            c_clr_reg   <= b_clr_reg;
            o_valid_reg <= c_valid_reg;
            o_moved_reg <= c_moved;
            valid_reg   <= valid_next;
        end
    end

    // slot state updates in item order at the compare stage
    always_comb
    begin
        valid_next = valid_reg;
        if (c_valid_reg)
        begin
            if (c_clr_reg)
            begin
                valid_next = '0;
            end
            else if (c_rem_reg)
            begin
                valid_next[c_idx_reg] = 1'b0;
            end
            else if (c_moved)
            begin
                valid_next[c_idx_reg] = 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (accept)
            begin
                b_idx_reg <= in_idx;
                b_x_reg   <= report.pos_x;
                b_y_reg   <= report.pos_y;
                b_h_reg   <= report.heading;
            end
            b_fwd_data_reg <= c_entry;
            c_idx_reg      <= b_idx_reg;
            c_x_reg        <= b_x_reg;
            c_y_reg        <= b_y_reg;
            c_h_reg        <= b_h_reg;
            c_sqx_reg      <= $unsigned(prod_x);
            c_sqy_reg      <= $unsigned(prod_y);
            c_da_reg       <= da;
        end
    end

    assign result.valid = o_valid_reg;
    assign result.moved = o_moved_reg;

    `POMDF_ASSERT_NEXT(a_clear_empties, clk, rst_n, advance && c_valid_reg && c_clr_reg, valid_reg == '0, "clear left a slot occupied")
    `POMDF_ASSERT_NEXT(a_new_slot_moved, clk, rst_n, advance && c_valid_reg && c_rep_reg && !c_slot_valid, o_valid_reg && o_moved_reg, "first report to empty slot not moved")
    `POMDF_ASSERT_NEXT(a_non_report_still, clk, rst_n, advance && c_valid_reg && !c_rep_reg, o_valid_reg && !o_moved_reg, "non-report word flagged as moved")
    `POMDF_ASSERT_SAME(a_fwd_only_report, clk, rst_n, b_fwd_reg, b_valid_reg && b_rep_reg, "forwarded entry on a non-report word")

endmodule

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: testbench for per_object_motion_deadband_filter
// Drives report, remove, clear and unused words through the valid/ready
// channel, keeps its own slot table and thresholds, and checks the moved flag
// of every result word in order against the value that table predicts.
// ---------------------------------------------------------------------------

module tb_top;

    localparam int POS_W = 24;
    localparam int SLOTS = 256;
    localparam pomdf_pkg::kind_t KIND_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    logic cfg_we;
    pomdf_pkg::cfg_idx_t cfg_index;
    logic [pomdf_pkg::CFG_DATA_W-1:0] cfg_wdata;

    pomdf_in_if #(.POS_W(POS_W)) report_ch ();
    pomdf_out_if result_ch ();

    per_object_motion_deadband_filter #(
        .VEHICLE_SLOTS(SLOTS),
        .POS_WIDTH    (POS_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .report   (report_ch),
        .result   (result_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    // Shadow of the filter: thresholds and the last entry passed as moved per slot.
    logic [pomdf_pkg::DIST_THR_W-1:0]   dist_thr;
    logic [pomdf_pkg::ANGLE_THR_W-1:0]  angle_thr;
    bit   [SLOTS-1:0]                   occupied;
    logic signed [POS_W-1:0]            kept_x [SLOTS];
    logic signed [POS_W-1:0]            kept_y [SLOTS];
    logic signed [pomdf_pkg::HEAD_W-1:0] kept_h [SLOTS];

    bit expected_moved[$];
    bit steady;
    int words_sent;
    int results_seen;
    int moved_seen;
    int mismatches;
    int threshold_sets;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("TB_ERROR");
        $finish;
    end

    // Update the shadow table with one accepted word; return the moved flag.
    function automatic bit predict_moved(input pomdf_pkg::kind_t k,
                                         input logic [pomdf_pkg::SLOT_W-1:0] s,
                                         input logic signed [POS_W-1:0] x,
                                         input logic signed [POS_W-1:0] y,
                                         input logic signed [pomdf_pkg::HEAD_W-1:0] h);
        longint dx;
        longint dy;
        longint dh;
        logic [63:0] dsq;
        bit mv;
        mv = 1'b0;
        if (k == pomdf_pkg::KIND_CLEAR)
        begin
            occupied = '0;
        end
        else if (k == pomdf_pkg::KIND_REMOVE)
        begin
            occupied[s] = 1'b0;
        end
        else if (k == pomdf_pkg::KIND_REPORT)
        begin
            if (!occupied[s])
            begin
                mv = 1'b1;
            end
            else
            begin
                dx = longint'(x) - longint'(kept_x[s]);
                dy = longint'(y) - longint'(kept_y[s]);
                dh = longint'(h) - longint'(kept_h[s]);
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                if (dh < 0) dh = -dh;
                dsq = 64'(dx * dx + dy * dy);
                mv = (dsq >= 64'(dist_thr)) || (64'(dh) >= 64'(angle_thr));
            end
            if (mv)
            begin
                occupied[s] = 1'b1;
                kept_x[s] = x;
                kept_y[s] = y;
                kept_h[s] = h;
            end
        end
        return mv;
    endfunction

    // Called at a falling edge; returns at a falling edge with valid left high.
    task automatic send_word(input pomdf_pkg::kind_t k,
                             input logic [pomdf_pkg::SLOT_W-1:0] s,
                             input logic signed [POS_W-1:0] x,
                             input logic signed [POS_W-1:0] y,
                             input logic signed [pomdf_pkg::HEAD_W-1:0] h);
        bit mv_pred;
        // idle at random unless in a steady stretch
        while (!steady && $urandom_range(99) < 17)
        begin
            report_ch.valid <= 1'b0;
            @(negedge clk);
        end
        report_ch.valid        <= 1'b1;
        report_ch.kind         <= k;
        report_ch.vehicle_slot <= s;
        report_ch.pos_x        <= x;
        report_ch.pos_y        <= y;
        report_ch.heading      <= h;
        @(posedge clk);
        while (!report_ch.ready) @(posedge clk);
        mv_pred = predict_moved(k, s, x, y, h);
        expected_moved = {expected_moved, mv_pred};
        words_sent++;
        @(negedge clk);
    endtask

    // Drop valid and hold until every expected word has come back.
    task automatic settle_block();
        report_ch.valid <= 1'b0;
        while (expected_moved.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_thresholds(input logic [31:0] dist_word, input logic [31:0] angle_word);
        cfg_we    <= 1'b1;
        cfg_index <= pomdf_pkg::CFG_DIST_THR;
        cfg_wdata <= dist_word;
        @(negedge clk);
        cfg_index <= pomdf_pkg::CFG_ANGLE_THR;
        cfg_wdata <= angle_word;
        @(negedge clk);
        cfg_we <= 1'b0;
        dist_thr  = dist_word;
        angle_thr = angle_word[pomdf_pkg::ANGLE_THR_W-1:0];
        threshold_sets++;
    endtask

    // Reset thresholds, exact boundaries, extremes, remove, clear, unused kind.
    task automatic test_directed();
        send_word(pomdf_pkg::KIND_REPORT, 8'd3, 24'sd100, 24'sd200, 17'sd500);
        send_word(pomdf_pkg::KIND_REPORT, 8'd3, 24'sd100, 24'sd200, 17'sd500);
        send_word(pomdf_pkg::KIND_REPORT, 8'd3, 24'sd110, 24'sd200, 17'sd500);
        send_word(pomdf_pkg::KIND_REPORT, 8'd3, 24'sd119, 24'sd200, 17'sd500);
        send_word(pomdf_pkg::KIND_REPORT, 8'd3, 24'sd116, 24'sd208, 17'sd500);
        send_word(pomdf_pkg::KIND_REPORT, 8'd3, 24'sd116, 24'sd208, 17'sd599);
        send_word(pomdf_pkg::KIND_REPORT, 8'd3, 24'sd116, 24'sd208, 17'sd600);
        send_word(pomdf_pkg::KIND_REPORT, 8'd3, 24'sd116, 24'sd208, 17'sd500);
        send_word(pomdf_pkg::KIND_REPORT, 8'd255,
                  -24'sd8388608, 24'sd8388607, -17'sd65536);
        send_word(pomdf_pkg::KIND_REPORT, 8'd255,
                  24'sd8388607, -24'sd8388608, 17'sd65535);
        send_word(pomdf_pkg::KIND_REPORT, 8'd255,
                  24'sd8388607, -24'sd8388608, 17'sd65535);
        send_word(pomdf_pkg::KIND_REMOVE, 8'd255, '0, '0, '0);
        send_word(pomdf_pkg::KIND_REPORT, 8'd255, '0, '0, '0);
        // unused kind must leave slot 3 untouched
        send_word(KIND_UNUSED, 8'd3, -24'sd1, -24'sd1, -17'sd1);
        send_word(pomdf_pkg::KIND_REPORT, 8'd3, 24'sd116, 24'sd208, 17'sd500);
        send_word(pomdf_pkg::KIND_REMOVE, 8'd7, 24'sd5, 24'sd5, 17'sd5);
        send_word(pomdf_pkg::KIND_CLEAR, 8'd0, '0, '0, '0);
        send_word(pomdf_pkg::KIND_REPORT, 8'd3, 24'sd116, 24'sd208, 17'sd500);
        send_word(pomdf_pkg::KIND_REPORT, 8'd0, -24'sd1, -24'sd1, 17'sd36000);
        send_word(pomdf_pkg::KIND_REPORT, 8'd0, -24'sd1, -24'sd1, 17'sd36000);
        send_word(pomdf_pkg::KIND_REPORT, 8'd0, -24'sd1, -24'sd1, -17'sd36000);
        send_word(pomdf_pkg::KIND_REPORT, 8'd255, 24'sd0, 24'sd0, 17'sd0);
        settle_block();
    endtask

    // Zero and full-scale thresholds, and an angle write with stray upper bits.
    task automatic test_threshold_extremes();
        set_thresholds(32'd0, 32'd0);
        send_word(pomdf_pkg::KIND_REPORT, 8'd10, 24'sd50, 24'sd50, 17'sd0);
        send_word(pomdf_pkg::KIND_REPORT, 8'd10, 24'sd50, 24'sd50, 17'sd0);
        send_word(pomdf_pkg::KIND_REPORT, 8'd10, 24'sd51, 24'sd50, 17'sd1);
        settle_block();
        set_thresholds(32'hFFFF_FFFF, 32'h0001_FFFF);
        send_word(pomdf_pkg::KIND_REPORT, 8'd10,
                  -24'sd8388608, -24'sd8388608, -17'sd65536);
        send_word(pomdf_pkg::KIND_REPORT, 8'd10,
                  24'sd8388607, 24'sd8388607, 17'sd65535);
        send_word(pomdf_pkg::KIND_REPORT, 8'd10,
                  24'sd8388607, 24'sd8388607, -17'sd65536);
        send_word(pomdf_pkg::KIND_REPORT, 8'd10,
                  24'sd8388607, 24'sd8388607, 17'sd65534);
        send_word(pomdf_pkg::KIND_REPORT, 8'd10, 24'sd0, 24'sd0, -17'sd65536);
        settle_block();
        set_thresholds(32'd1, 32'hFFFE_0032);
        send_word(pomdf_pkg::KIND_REPORT, 8'd10, 24'sd0, 24'sd0, -17'sd65536);
        send_word(pomdf_pkg::KIND_REPORT, 8'd10, 24'sd0, 24'sd0, -17'sd65487);
        send_word(pomdf_pkg::KIND_REPORT, 8'd10, 24'sd0, 24'sd0, -17'sd65486);
        send_word(pomdf_pkg::KIND_REPORT, 8'd10, 24'sd1, 24'sd0, -17'sd65486);
        settle_block();
    endtask

    // Mostly follow-up reports near the thresholds on a few slots, plus noise.
    task automatic send_random_word();
        logic [pomdf_pkg::SLOT_W-1:0] s;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [pomdf_pkg::HEAD_W-1:0] h;
        int r;
        int root;
        int ahi;
        int dx;
        int dy;
        int dh;
        r = $urandom_range(99);
        s = pomdf_pkg::SLOT_W'($urandom_range(15) * 17);
        x = POS_W'($urandom);
        y = POS_W'($urandom);
        h = pomdf_pkg::HEAD_W'($urandom);
        if (r < 70)
        begin
            if (occupied[s])
            begin
                root = int'($sqrt(real'(dist_thr)));
                ahi  = int'(angle_thr);
                dx = 0;
                dy = 0;
                dh = 0;
                case ($urandom_range(2))
                    0:
                    begin
                        dx = root + int'($urandom_range(4)) - 2;
                        dy = int'($urandom_range(3));
                    end
                    1:
                    begin
                        dh = ahi + int'($urandom_range(4)) - 2;
                    end
                    default:
                    begin
                        dx = int'($urandom_range(root + 2));
                        dy = int'($urandom_range(root + 2));
                        dh = int'($urandom_range(ahi + 2));
                    end
                endcase
                if ($urandom_range(1)) dx = -dx;
                if ($urandom_range(1)) dy = -dy;
                if ($urandom_range(1)) dh = -dh;
                x = POS_W'(kept_x[s] + dx);
                y = POS_W'(kept_y[s] + dy);
                h = pomdf_pkg::HEAD_W'(kept_h[s] + dh);
            end
            send_word(pomdf_pkg::KIND_REPORT, s, x, y, h);
        end
        else if (r < 80)
            send_word(pomdf_pkg::KIND_REPORT, pomdf_pkg::SLOT_W'($urandom), x, y, h);
        else if (r < 86)
            send_word(pomdf_pkg::KIND_REMOVE, s, x, y, h);
        else if (r < 88)
            send_word(pomdf_pkg::KIND_REMOVE, pomdf_pkg::SLOT_W'($urandom), x, y, h);
        else if (r < 91)
            send_word(pomdf_pkg::KIND_CLEAR, pomdf_pkg::SLOT_W'($urandom), x, y, h);
        else
            send_word(KIND_UNUSED, pomdf_pkg::SLOT_W'($urandom), x, y, h);
    endtask

    task automatic test_random_phase(input logic [31:0] dist_word, input logic [31:0] angle_word,
                                     input int count, input bit no_idle);
        settle_block();
        set_thresholds(dist_word, angle_word);
        steady = no_idle;
        repeat (count) send_random_word();
        settle_block();
        steady = 1'b0;
    endtask

    // Sink side: stall at random unless in a steady stretch.
    always @(negedge clk)
        result_ch.ready <= steady || ($urandom_range(99) >= 17);

    always @(posedge clk)
    begin : check_moved
        bit want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            results_seen++;
            if (result_ch.moved === 1'b1) moved_seen++;
            if (expected_moved.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result word, expected none, actual moved %b",
                         $time, result_ch.moved);
            end
            else
            begin
                want = expected_moved.pop_front();
                if (result_ch.moved !== want)
                begin
                    mismatches++;
                    $display("%0t: moved mismatch, expected %b, actual %b",
                             $time, want, result_ch.moved);
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = pomdf_pkg::CFG_DIST_THR;
        cfg_wdata = '0;
        report_ch.valid = 1'b0;
        report_ch.kind = pomdf_pkg::KIND_REPORT;
        report_ch.vehicle_slot = '0;
        report_ch.pos_x = '0;
        report_ch.pos_y = '0;
        report_ch.heading = '0;
        result_ch.ready = 1'b0;
        steady = 1'b0;
        dist_thr = pomdf_pkg::DIST_THR_RESET;
        angle_thr = pomdf_pkg::ANGLE_THR_RESET;
        occupied = '0;
        words_sent = 0;
        results_seen = 0;
        moved_seen = 0;
        mismatches = 0;
        threshold_sets = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_threshold_extremes();
        test_random_phase(32'd100, 32'd100, 210, 1'b0);
        test_random_phase(32'd0, 32'($urandom_range(300)), 200, 1'b0);
        test_random_phase(32'($urandom_range(400)), 32'($urandom_range(300)), 220, 1'b1);
        test_random_phase($urandom, 32'($urandom_range(131071)), 200, 1'b0);
        test_random_phase(32'hFFFF_FFFF, 32'($urandom_range(2000)), 200, 1'b0);
        test_random_phase(32'($urandom_range(5000)), 32'h0001_FFFF, 220, 1'b0);

        settle_block();
        repeat (8) @(posedge clk);
        $display("Sent %0d words over %0d threshold settings; %0d results checked, %0d moved.",
                 words_sent, threshold_sets, results_seen, moved_seen);
        $display("Mismatches: %0d, results still outstanding: %0d.",
                 mismatches, expected_moved.size());
        if (mismatches == 0 && expected_moved.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### per_object_motion_deadband_filter.f
+incdir+src
src/pomdf_pkg.sv
src/pomdf_if.sv
src/pomdf_ram.sv
src/per_object_motion_deadband_filter.sv
verif/tb_top.sv
